// ----- rtl/core/hpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants of the heater PID control block: operating
// modes, register indexes and field widths.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int unsigned TempW  = 9;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DriveW = 8;
  localparam int unsigned IntegW = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DriveW-1:0] DriveMax        = 8'd255;
  localparam logic [DriveW-1:0] HighPowerReset  = 8'd255;
  localparam logic [DriveW-1:0] LowPowerReset   = 8'd64;

  // Mode code 3 is unused and behaves as off.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_BANG = 2'd1,
    MODE_PID  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 3'd0,
    CFG_TARGET_TEMP = 3'd1,
    CFG_P_GAIN      = 3'd2,
    CFG_I_GAIN      = 3'd3,
    CFG_D_GAIN      = 3'd4,
    CFG_INTEG_LIMIT = 3'd5,
    CFG_HIGH_POWER  = 3'd6,
    CFG_LOW_POWER   = 3'd7
  } cfg_idx_e;

  // Error, clamped integral, derivative, bang drive and flag after the input stage.
  typedef struct packed {
    logic                     is_pid;
    logic [DriveW-1:0]        bang_drive;
    logic                     at_target;
    logic signed [TempW:0]    err;
    logic signed [IntegW-1:0] acc;
    logic signed [TempW:0]    delta;
  } s1_t;

  // Partial products after the multiply stage.
  typedef struct packed {
    logic                     is_pid;
    logic [DriveW-1:0]        bang_drive;
    logic                     at_target;
    logic signed [26:0]       p_term;
    logic signed [33:0]       i_term;
    logic signed [26:0]       d_term;
  } s2_t;

endpackage
`default_nettype wire

// ----- rtl/core/heater_pid_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// heater_pid_control
// Heater drive from one measured temperature per tick: off, bang-bang or PID
// with clamped integral and derivative on measurement.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------
//  in       | in  | in_valid_i/in_ready_o   | measured_temp_i[8:0]
//  out      | out | out_valid_o/out_ready_i | drive_o[7:0], at_target_o
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i[2:0], cfg_data_i[15:0]
//
//  One word per cycle is accepted while the output side is not stalled.
//  The integral and previous sample update at input accept in PID mode, so
//  the three stages (error/clamp, multiply, sum/saturate) run back to back.
//  Each stage holds only while its successor is full and stalled.
//  Reset clears integral, previous sample, valid flags and all config but power.
// ----------------------------------------------------------------------------
module heater_pid_control
  import hpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [TempW-1:0]    measured_temp_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [DriveW-1:0]        drive_o,
  output logic                     at_target_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [1:0]        mode_q;
  logic [TempW-1:0]  target_q;
  logic [GainW-1:0]  p_gain_q, i_gain_q, d_gain_q, limit_q;
  logic [DriveW-1:0] high_power_q, low_power_q;

  // controller state
  logic signed [IntegW-1:0] integral_q, integral_d;
  logic [TempW-1:0]         prev_q;

  // pipeline
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  logic [DriveW-1:0] drive_q, drive_d;
  logic              at_target_q;
  logic              in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      target_q     <= '0;
      p_gain_q     <= '0;
      i_gain_q     <= '0;
      d_gain_q     <= '0;
      limit_q      <= '0;
      high_power_q <= HighPowerReset;
      low_power_q  <= LowPowerReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:        mode_q       <= cfg_data_i[1:0];
        CFG_TARGET_TEMP: target_q     <= cfg_data_i[TempW-1:0];
        CFG_P_GAIN:      p_gain_q     <= cfg_data_i;
        CFG_I_GAIN:      i_gain_q     <= cfg_data_i;
        CFG_D_GAIN:      d_gain_q     <= cfg_data_i;
        CFG_INTEG_LIMIT: limit_q      <= cfg_data_i;
        CFG_HIGH_POWER:  high_power_q <= cfg_data_i[DriveW-1:0];
        CFG_LOW_POWER:   low_power_q  <= cfg_data_i[DriveW-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage advance: a stage loads when it is empty or its word moves on.
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_fire    = in_valid_i && in_ready_o;

  // Stage 1: error, clamped integral, derivative, bang-bang and flag.
  logic signed [IntegW:0] acc_wide, lim_pos, lim_neg, acc_sel;
  logic [12:0]            ceil_lhs, ceil_rhs;
  logic [13:0]            flag_lhs, flag_rhs;

  always_comb begin
    s1_d.err   = $signed({1'b0, target_q}) - $signed({1'b0, measured_temp_i});
    s1_d.delta = $signed({1'b0, measured_temp_i}) - $signed({1'b0, prev_q});
    acc_wide   = $signed({integral_q[IntegW-1], integral_q})
               + $signed({{(IntegW-TempW){s1_d.err[TempW]}}, s1_d.err});
    lim_pos    = $signed({2'b00, limit_q});
    lim_neg    = -lim_pos;
    if (acc_wide > lim_pos) begin
      acc_sel = lim_pos;
    end else if (acc_wide < lim_neg) begin
      acc_sel = lim_neg;
    end else begin
      acc_sel = acc_wide;
    end
    s1_d.acc = acc_sel[IntegW-1:0];

    // temp < floor(11*target/10)  <=>  10*(temp+1) <= 11*target
    ceil_lhs = ({4'b0, measured_temp_i} + 13'd1) * 13'd10;
    ceil_rhs = {4'b0, target_q} * 13'd11;
    flag_lhs = {5'b0, measured_temp_i} * 14'd20;
    flag_rhs = {5'b0, target_q} * 14'd19;

    s1_d.at_target  = flag_lhs > flag_rhs;
    s1_d.is_pid     = mode_q == MODE_PID;
    s1_d.bang_drive = '0;
    if (mode_q == MODE_BANG) begin
      if (measured_temp_i < target_q) begin
        s1_d.bang_drive = high_power_q;
      end else if (ceil_lhs <= ceil_rhs) begin
        s1_d.bang_drive = low_power_q;
      end
    end

    integral_d = s1_d.is_pid ? s1_d.acc : integral_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_q     <= '0;
    end else if (in_fire && mode_q == MODE_PID) begin
      integral_q <= integral_d;
      prev_q     <= measured_temp_i;
    end
  end

  // Stage 2: gain products.
  always_comb begin
    s2_d.is_pid     = s1_q.is_pid;
    s2_d.bang_drive = s1_q.bang_drive;
    s2_d.at_target  = s1_q.at_target;
    s2_d.p_term     = $signed({1'b0, p_gain_q}) * s1_q.err;
    s2_d.i_term     = $signed({1'b0, i_gain_q}) * s1_q.acc;
    s2_d.d_term     = $signed({1'b0, d_gain_q}) * s1_q.delta;
  end

  // Stage 3: sum, shift and saturate, or pass the bang-bang drive.
  logic signed [34:0] pid_sum;

  always_comb begin
    pid_sum = $signed({{8{s2_q.p_term[26]}}, s2_q.p_term})
            + $signed({s2_q.i_term[33], s2_q.i_term})
            - $signed({{8{s2_q.d_term[26]}}, s2_q.d_term});
    if (!s2_q.is_pid) begin
      drive_d = s2_q.bang_drive;
    end else if (pid_sum[34]) begin
      drive_d = '0;
    end else if (|pid_sum[33:16]) begin
      drive_d = DriveMax;
    end else begin
      drive_d = pid_sum[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire)       s1_q <= s1_d;
    if (en2 && v1_q)   s2_q <= s2_d;
    if (en3 && v2_q) begin
      drive_q     <= drive_d;
      at_target_q <= s2_q.at_target;
    end
  end

  assign out_valid_o = v3_q;
  assign drive_o     = drive_q;
  assign at_target_o = at_target_q;

`ifndef ASSERT_OFF
  a_integral_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q == MODE_PID |=>
      (integral_q <= $signed({2'b00, $past(limit_q)}))
      && (integral_q >= -$signed({2'b00, $past(limit_q)})))
    else $error("integral outside clamp after PID tick");

  a_state_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q != MODE_PID |=> $stable(integral_q) && $stable(prev_q))
    else $error("PID state changed outside PID mode");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v2_q))
    else $error("result appeared without a word in stage 2");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_heater_pid_control.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heater_pid_control
// Self-checking bench for the heater drive block. A scoreboard object keeps
// its own copy of the registers, the integral and the previous sample, and
// works out drive and at_target for every accepted temperature word. Directed
// words cover the extremes of each mode first. Random phases follow, each
// with a new register setting and temperatures mostly near the target.
// Both handshake sides idle at random, except during one calm stretch.
// ----------------------------------------------------------------------------
module tb_heater_pid_control
  import hpc_pkg::*;
();

  localparam int PipeDepth  = 3;
  localparam int RandWords  = 1800;

  typedef struct {
    logic [DriveW-1:0] drive;
    logic              at_target;
  } heat_word_t;

  class heater_scoreboard;
    logic [1:0]          mode;
    logic [TempW-1:0]    target;
    logic [GainW-1:0]    p_gain;
    logic [GainW-1:0]    i_gain;
    logic [GainW-1:0]    d_gain;
    logic [GainW-1:0]    integ_limit;
    logic [DriveW-1:0]   high_power;
    logic [DriveW-1:0]   low_power;
    int                  integral;
    int                  prev_temp;
    heat_word_t          pending_q[$];
    int                  errors;

    function new();
      mode        = MODE_OFF;
      target      = '0;
      p_gain      = '0;
      i_gain      = '0;
      d_gain      = '0;
      integ_limit = '0;
      high_power  = HighPowerReset;
      low_power   = LowPowerReset;
      integral    = 0;
      prev_temp   = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_MODE:        mode        = data[1:0];
        CFG_TARGET_TEMP: target      = data[TempW-1:0];
        CFG_P_GAIN:      p_gain      = data;
        CFG_I_GAIN:      i_gain      = data;
        CFG_D_GAIN:      d_gain      = data;
        CFG_INTEG_LIMIT: integ_limit = data;
        CFG_HIGH_POWER:  high_power  = data[DriveW-1:0];
        CFG_LOW_POWER:   low_power   = data[DriveW-1:0];
        default: ;
      endcase
    endfunction

    function void note_temp(logic [TempW-1:0] temp);
      int         tmp;
      int         tgt;
      int         err;
      int         acc;
      int         delta;
      int         lim;
      longint     sum;
      heat_word_t w;
      tmp = temp;
      tgt = target;
      w.at_target = (20 * tmp > 19 * tgt);
      w.drive     = '0;
      if (mode == MODE_BANG) begin
        if (tmp < tgt) w.drive = high_power;
        else if (tmp < (11 * tgt) / 10) w.drive = low_power;
      end else if (mode == MODE_PID) begin
        err = tgt - tmp;
        lim = integ_limit;
        // add first, then clamp, so a lowered limit bites on this tick
        acc = integral + err;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        delta     = tmp - prev_temp;
        integral  = acc;
        prev_temp = tmp;
        sum = longint'(p_gain) * err + longint'(i_gain) * acc
            - longint'(d_gain) * delta;
        if (sum < 0) w.drive = '0;
        else if (sum / 256 > 255) w.drive = DriveMax;
        else w.drive = 8'(sum / 256);
      end
      pending_q.push_back(w);
    endfunction

    function void check_result(logic [DriveW-1:0] drive, logic at_target);
      heat_word_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got drive %0d at_target %0b",
                 $time, drive, at_target);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (drive !== exp_w.drive) begin
        $display("%0t: drive: expected %0d, got %0d", $time, exp_w.drive, drive);
        errors++;
      end
      if (at_target !== exp_w.at_target) begin
        $display("%0t: at_target: expected %0b, got %0b",
                 $time, exp_w.at_target, at_target);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [TempW-1:0]    measured_temp_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [DriveW-1:0]   drive_o;
  logic                at_target_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  heater_scoreboard sb = new();
  bit               calm = 1'b0;
  int               words_sent = 0;

  heater_pid_control dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .measured_temp_i(measured_temp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_o        (drive_o),
    .at_target_o    (at_target_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Sink side: check accepted words, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(drive_o, at_target_o);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  task automatic send_temp(input logic [TempW-1:0] temp);
    while (!calm && ($urandom_range(0, 99) < 31)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    measured_temp_i <= temp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_temp(temp);
    words_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the input side until every pending word is back and the pipe is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // Set bits above the register width now and then; the block must drop them.
  function automatic logic [CfgDataW-1:0] with_junk(input logic [CfgDataW-1:0] val,
                                                     input int w);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    if ($urandom_range(0, 3) == 0) return val | (junk << w);
    return val;
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return GainW'($urandom);
      default: return GainW'($urandom_range(0, 16'h0300));
    endcase
  endfunction

  initial begin
    int               ph;
    int               n;
    int               t;
    logic [1:0]       md;
    logic [TempW-1:0] tg;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // off mode from reset, flag still live with target zero
    send_temp(9'd0);
    send_temp(9'd511);
    send_temp(9'd1);
    settle();

    // unused mode code acts as off
    write_reg(CFG_TARGET_TEMP, 16'd100);
    write_reg(CFG_MODE, 16'd3);
    send_temp(9'd96);
    send_temp(9'd95);
    send_temp(9'd511);
    settle();

    // bang-bang edges around target and the 1.1x ceiling
    write_reg(CFG_HIGH_POWER, 16'd200);
    write_reg(CFG_LOW_POWER, 16'd50);
    write_reg(CFG_MODE, CfgDataW'(MODE_BANG));
    send_temp(9'd99);
    send_temp(9'd100);
    send_temp(9'd109);
    send_temp(9'd110);
    send_temp(9'd0);
    settle();

    // PID: negative sum, clamp both ways, saturation high
    write_reg(CFG_P_GAIN, 16'h0100);
    write_reg(CFG_I_GAIN, 16'h0040);
    write_reg(CFG_D_GAIN, 16'h0400);
    write_reg(CFG_INTEG_LIMIT, 16'd20);
    write_reg(CFG_MODE, CfgDataW'(MODE_PID));
    send_temp(9'd60);
    send_temp(9'd60);
    send_temp(9'd0);
    send_temp(9'd200);
    send_temp(9'd100);
    settle();

    // lower the limit under a stored integral, then zero it
    write_reg(CFG_INTEG_LIMIT, 16'd5);
    send_temp(9'd100);
    settle();
    write_reg(CFG_INTEG_LIMIT, 16'd0);
    send_temp(9'd90);
    send_temp(9'd100);
    settle();

    // full-scale gains and target
    write_reg(CFG_P_GAIN, 16'hFFFF);
    write_reg(CFG_I_GAIN, 16'hFFFF);
    write_reg(CFG_D_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_LIMIT, 16'hFFFF);
    write_reg(CFG_TARGET_TEMP, 16'd511);
    send_temp(9'd0);
    send_temp(9'd511);
    settle();

    write_reg(CFG_HIGH_POWER, 16'd0);
    write_reg(CFG_LOW_POWER, 16'd255);
    write_reg(CFG_MODE, CfgDataW'(MODE_BANG));
    send_temp(9'd510);
    send_temp(9'd511);
    settle();

    ph = 0;
    words_sent = 0;
    while (words_sent < RandWords) begin
      case ($urandom_range(0, 9))
        0:          md = MODE_OFF;
        1:          md = 2'd3;
        2, 3, 4:    md = MODE_BANG;
        default:    md = MODE_PID;
      endcase
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       tg = '0;
          1:       tg = '1;
          default: tg = TempW'($urandom);
        endcase
        write_reg(CFG_TARGET_TEMP, with_junk(16'(tg), TempW));
      end
      if ($urandom_range(0, 1) == 0) write_reg(CFG_P_GAIN, pick_gain());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_I_GAIN, pick_gain());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_D_GAIN, pick_gain());
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(CFG_INTEG_LIMIT, '0);
          1:       write_reg(CFG_INTEG_LIMIT, '1);
          2:       write_reg(CFG_INTEG_LIMIT, CfgDataW'($urandom));
          default: write_reg(CFG_INTEG_LIMIT, CfgDataW'($urandom_range(0, 400)));
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_HIGH_POWER, with_junk(CfgDataW'($urandom_range(0, 255)), DriveW));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_LOW_POWER, with_junk(CfgDataW'($urandom_range(0, 255)), DriveW));
      end
      write_reg(CFG_MODE, with_junk(16'(md), 2));

      calm = (ph >= 8 && ph < 14);
      n = int'($urandom_range(5, 60));
      repeat (n) begin
        if ($urandom_range(0, 3) != 0) begin
          t = int'(sb.target) + int'($urandom_range(0, 60)) - 30;
          if (t < 0) t = 0;
          if (t > 511) t = 511;
        end else begin
          t = int'($urandom_range(0, 511));
        end
        send_temp(TempW'(t));
      end
      settle();
      ph++;
    end

    calm = 1'b0;
    settle();
    if (sb.errors == 0) begin
      $display("heater_pid_control: match");
    end else begin
      $display("heater_pid_control: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("heater_pid_control: mismatch");
    $finish;
  end

endmodule
